FILE: rtl/core/edp_pkg.sv
// ----------------------------------------------------------------------------
// edp_pkg
// Shared constants, types and state codes of the energy percentile unit.
// ----------------------------------------------------------------------------
`default_nettype none

package edp_pkg;

    localparam int MAX_SAMPLES   = 4096;
    localparam int SAMPLE_W      = 16;
    localparam int CNT_W         = $clog2(MAX_SAMPLES + 1);
    localparam int ADDR_W        = $clog2(MAX_SAMPLES);
    localparam int SQ_W          = 2 * SAMPLE_W - 1;
    localparam int ENERGY_W      = SQ_W + ADDR_W;
    localparam int LEVEL_W       = 5;
    localparam int SCALED_W      = ENERGY_W + LEVEL_W;
    localparam int FRAC_BITS     = 16;
    localparam int FRAC_W        = FRAC_BITS + 1;
    localparam int STEP_W        = $clog2(FRAC_BITS);

    localparam int STEP_PERCENT  = 5;
    localparam int FULL_PERCENT  = 100;
    localparam int SHARE_DIV     = FULL_PERCENT / STEP_PERCENT;
    localparam int LEVEL_COUNT   = SHARE_DIV - 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_FIN,
        S_TEST,
        S_RSQ,
        S_ACC,
        S_DIV,
        S_OUT
    } edp_state_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] numer;
        logic [CNT_W-1:0] denom;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [FRAC_W-1:0] quot;
    } div_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/edp_if.sv
// ----------------------------------------------------------------------------
// edp_if
// Valid/ready channels for frame samples and percentile results.
// ----------------------------------------------------------------------------
`default_nettype none

interface edp_in_if
    import edp_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface edp_out_if
    import edp_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level;
    logic [CNT_W-1:0]   prefix_length;
    logic [FRAC_W-1:0]  fraction;
    logic               last_level;

    modport source (output valid, output level, output prefix_length,
                    output fraction, output last_level, input ready);
    modport sink   (input valid, input level, input prefix_length,
                    input fraction, input last_level, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/energy_distribution_percentiles_unit.sv
// ----------------------------------------------------------------------------
// energy_distribution_percentiles_unit
// Loads a frame of samples, then walks the stored frame to find the prefix
// lengths that reach each 5 percent share of the total energy.
// ----------------------------------------------------------------------------
// Load: frame.ready drops in S_SQ after each accepted sample, as the squarer
//   and accumulator are shared. Walk: a memory read, square and accumulate
//   per stored sample, plus the test, the 16-step divider and the result
//   per level.
// Reset clears the sequencer, counters and sums; the sample memory is not
//   cleared and is only read below the count written by the current frame.
// ----------------------------------------------------------------------------
`default_nettype none

module energy_distribution_percentiles_unit
    import edp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    edp_in_if.sink      frame,
    edp_out_if.source   result
);

    edp_state_t                 state_reg,   state_next;
    logic        [CNT_W-1:0]    count_reg,   count_next;
    logic        [ENERGY_W-1:0] total_reg,   total_next;
    logic        [SCALED_W-1:0] prefix_reg,  prefix_next;
    logic        [SCALED_W-1:0] goal_reg,    goal_next;
    logic        [CNT_W-1:0]    idx_reg,     idx_next;
    logic        [LEVEL_W-1:0]  level_reg,   level_next;
    logic                       pend_reg,    pend_next;
    logic signed [SAMPLE_W-1:0] sample_reg,  sample_next;
    logic                       last_reg,    last_next;
    logic                       ovalid_reg,  ovalid_next;
    logic        [LEVEL_W-1:0]  olevel_reg,  olevel_next;
    logic        [CNT_W-1:0]    oprefix_reg, oprefix_next;
    logic        [FRAC_W-1:0]   ofrac_reg,   ofrac_next;
    logic                       olast_reg,   olast_next;

    logic        [SAMPLE_W-1:0] mem [MAX_SAMPLES];
    logic signed [SAMPLE_W-1:0] rd_reg;
    logic                       we;
    logic        [ADDR_W-1:0]   raddr;

    logic signed [SAMPLE_W-1:0] sq_operand;
    logic        [SQ_W-1:0]     sq;
    logic        [ENERGY_W-1:0] total_sum;
    div_req_t                   div_req;
    div_status_t                div_stat;

    assign sq_operand = (state_reg == S_RSQ) ? rd_reg : sample_reg;

    edp_square_unit u_square (
        .clk     (clk),
        .operand (sq_operand),
        .square  (sq)
    );

    edp_frac_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (div_req),
        .status (div_stat)
    );

    assign frame.ready          = (state_reg == S_IDLE);
    assign result.valid         = ovalid_reg;
    assign result.level         = olevel_reg;
    assign result.prefix_length = oprefix_reg;
    assign result.fraction      = ofrac_reg;
    assign result.last_level    = olast_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[count_reg[ADDR_W-1:0]] <= frame.sample;
        end
        rd_reg <= mem[raddr];
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        prefix_next   = prefix_reg;
        goal_next     = goal_reg;
        idx_next      = idx_reg;
        level_next    = level_reg;
        pend_next     = pend_reg;
        sample_next   = sample_reg;
        last_next     = last_reg;
        ovalid_next   = ovalid_reg;
        olevel_next   = olevel_reg;
        oprefix_next  = oprefix_reg;
        ofrac_next    = ofrac_reg;
        olast_next    = olast_reg;
        we            = 1'b0;
        raddr         = idx_reg[ADDR_W-1:0];
        div_req.start = 1'b0;
        div_req.numer = idx_reg;
        div_req.denom = count_reg;
        total_sum     = total_reg + (pend_reg ? ENERGY_W'(sq) : ENERGY_W'(0));

        if (ovalid_reg && result.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                total_next = total_sum;
                pend_next  = 1'b0;
                if (frame.valid)
                begin
                    sample_next = frame.sample;
                    last_next   = frame.last_sample;
                    if (count_reg < CNT_W'(MAX_SAMPLES))
                    begin
                        we         = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        state_next = S_SQ;
                    end
                    else if (frame.last_sample)
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_SQ:
            begin
                pend_next  = 1'b1;
                state_next = last_reg ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                total_next  = total_sum;
                goal_next   = SCALED_W'(total_sum);
                prefix_next = '0;
                idx_next    = '0;
                level_next  = LEVEL_W'(1);
                pend_next   = 1'b0;
                state_next  = S_TEST;
            end
            S_TEST:
            begin
                if ((idx_reg < count_reg) && (prefix_reg < goal_reg))
                begin
                    state_next = S_RSQ;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_RSQ:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                prefix_next = prefix_reg + SCALED_W'(sq) * SCALED_W'(SHARE_DIV);
                idx_next    = idx_reg + CNT_W'(1);
                state_next  = S_TEST;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!ovalid_reg || result.ready)
                begin
                    ovalid_next  = 1'b1;
                    olevel_next  = level_reg;
                    oprefix_next = idx_reg;
                    ofrac_next   = div_stat.quot;
                    olast_next   = (level_reg == LEVEL_W'(LEVEL_COUNT));
                    if (level_reg == LEVEL_W'(LEVEL_COUNT))
                    begin
                        count_next  = '0;
                        total_next  = '0;
                        prefix_next = '0;
                        goal_next   = '0;
                        idx_next    = '0;
                        level_next  = LEVEL_W'(1);
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        level_next = level_reg + LEVEL_W'(1);
                        goal_next  = goal_reg + SCALED_W'(total_reg);
                        state_next = S_TEST;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            total_reg  <= '0;
            prefix_reg <= '0;
            goal_reg   <= '0;
            idx_reg    <= '0;
            level_reg  <= LEVEL_W'(1);
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            total_reg  <= total_next;
            prefix_reg <= prefix_next;
            goal_reg   <= goal_next;
            idx_reg    <= idx_next;
            level_reg  <= level_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg  <= sample_next;
        last_reg    <= last_next;
        olevel_reg  <= olevel_next;
        oprefix_reg <= oprefix_next;
        ofrac_reg   <= ofrac_next;
        olast_reg   <= olast_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SAMPLES))
        else $error("sample count beyond store depth");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= count_reg)
        else $error("walk index past sample count");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == S_DIV)
        else $error("divider finished outside wait state");

    a_last_level: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && state_next == S_IDLE) |=>
            (ovalid_reg && olast_reg && olevel_reg == LEVEL_W'(LEVEL_COUNT)))
        else $error("frame closed without final level request");

endmodule

`default_nettype wire

FILE: rtl/core/edp_square_unit.sv
// ----------------------------------------------------------------------------
// edp_square_unit
// Shared registered squarer for sample energy.
// ----------------------------------------------------------------------------
`default_nettype none

module edp_square_unit
    import edp_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic signed [SAMPLE_W-1:0] operand,
    output logic         [SQ_W-1:0]         square
);

    logic signed [2*SAMPLE_W-1:0] product;
    logic        [SQ_W-1:0]       square_reg;

    assign product = operand * operand;
    assign square  = square_reg;

    always_ff @(posedge clk)
    begin
        square_reg <= product[SQ_W-1:0];
    end

endmodule

`default_nettype wire

FILE: rtl/core/edp_frac_div.sv
// ----------------------------------------------------------------------------
// edp_frac_div
// Bit-serial divider for prefix length over frame length in Q1.16.
// ----------------------------------------------------------------------------
`default_nettype none

module edp_frac_div
    import edp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire div_req_t    req,
    output div_status_t      status
);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [STEP_W-1:0] step_reg,  step_next;
    logic [CNT_W-1:0]  rem_reg,   rem_next;
    logic [CNT_W-1:0]  denom_reg, denom_next;
    logic [FRAC_W-1:0] quot_reg,  quot_next;
    logic [CNT_W:0]    rem_dbl;
    logic [CNT_W:0]    rem_diff;
    logic              qbit;

    assign status.done = done_reg;
    assign status.quot = quot_reg;

    always_comb
    begin
        rem_dbl    = {rem_reg, 1'b0};
        rem_diff   = rem_dbl - {1'b0, denom_reg};
        qbit       = (rem_dbl >= {1'b0, denom_reg});
        busy_next  = busy_reg;
        done_next  = 1'b0;
        step_next  = step_reg;
        rem_next   = rem_reg;
        denom_next = denom_reg;
        quot_next  = quot_reg;
        if (req.start)
        begin
            denom_next = req.denom;
            rem_next   = req.numer;
            step_next  = STEP_W'(FRAC_BITS - 1);
            if (req.denom == '0)
            begin
                quot_next = '0;
                done_next = 1'b1;
            end
            else if (req.numer >= req.denom)
            begin
                quot_next = FRAC_W'(1) << FRAC_BITS;
                done_next = 1'b1;
            end
            else
            begin
                quot_next = '0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next  = qbit ? rem_diff[CNT_W-1:0] : rem_dbl[CNT_W-1:0];
            quot_next = {quot_reg[FRAC_W-2:0], qbit};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        rem_reg   <= rem_next;
        denom_reg <= denom_next;
        quot_reg  <= quot_next;
    end

endmodule

`default_nettype wire

FILE: dv/energy_distribution_percentiles_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// energy_distribution_percentiles_unit_tb
// Feeds frames of signed samples through the request channel and checks each
// of the 19 percentile results per frame against an in-bench scoreboard that
// walks its own copy of the frame. Covers single-sample, silent and
// full-scale frames. Both sides idle and stall at random in several phases.
// ----------------------------------------------------------------------------

module energy_distribution_percentiles_unit_tb;

    import edp_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 240;
    localparam int PHASE_COUNT   = 4;
    localparam int DRAIN_CYCLES  = 64;

    typedef enum int {
        FILL_FULL,
        FILL_QUIET,
        FILL_SPARSE,
        FILL_SILENT,
        FILL_EXTREME
    } fill_mode_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
    } sample_req_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [CNT_W-1:0]   prefix_length;
        logic [FRAC_W-1:0]  fraction;
        logic               last_level;
    } level_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    edp_in_if  frame_if ();
    edp_out_if result_if ();

    energy_distribution_percentiles_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_if),
        .result (result_if)
    );

    sample_req_t                pending_samples [$];
    level_rsp_t                 expected_levels [$];
    logic signed [SAMPLE_W-1:0] frame_store [MAX_SAMPLES];
    int unsigned                frame_count;
    logic [63:0]                frame_energy;
    int                         idle_pct;
    int                         stall_pct;
    int                         error_count = 0;
    int                         cycle_count = 0;

    always #CLK_HALF clk = ~clk;

    function automatic logic [63:0] energy_of(logic signed [SAMPLE_W-1:0] s);
        longint v;
        v = s;
        return 64'(v * v);
    endfunction

    task automatic take_sample(sample_req_t req);
        logic [63:0] goal;
        logic [63:0] prefix;
        int unsigned walk;
        level_rsp_t  rsp;
        if (frame_count < MAX_SAMPLES)
        begin
            frame_store[frame_count] = req.sample;
            frame_energy = frame_energy + energy_of(req.sample);
            frame_count++;
        end
        if (req.last_sample)
        begin
            prefix = '0;
            walk   = 0;
            for (int k = 1; k <= LEVEL_COUNT; k++)
            begin
                goal = 64'(k) * frame_energy;
                while (walk < frame_count && 64'(SHARE_DIV) * prefix < goal)
                begin
                    prefix = prefix + energy_of(frame_store[walk]);
                    walk++;
                end
                rsp.level         = LEVEL_W'(k);
                rsp.prefix_length = CNT_W'(walk);
                rsp.fraction      = (frame_count != 0)
                                  ? FRAC_W'((64'(walk) << FRAC_BITS) / 64'(frame_count))
                                  : '0;
                rsp.last_level    = (k == LEVEL_COUNT);
                expected_levels.push_back(rsp);
            end
            frame_count  = 0;
            frame_energy = '0;
        end
    endtask

    function automatic logic signed [SAMPLE_W-1:0] next_sample(fill_mode_t mode);
        logic signed [SAMPLE_W-1:0] s;
        case (mode)
            FILL_FULL:   s = SAMPLE_W'($urandom);
            FILL_QUIET:  s = SAMPLE_W'($urandom_range(15)) - 16'sd8;
            FILL_SPARSE: s = ($urandom_range(7) == 0) ? SAMPLE_W'($urandom) : '0;
            FILL_SILENT: s = '0;
            default:
            begin
                case ($urandom_range(4))
                    0:       s = -16'sd32768;
                    1:       s = 16'sd32767;
                    2:       s = -16'sd1;
                    3:       s = 16'sd1;
                    default: s = '0;
                endcase
            end
        endcase
        return s;
    endfunction

    task automatic add_sample(logic signed [SAMPLE_W-1:0] s, logic last);
        sample_req_t req;
        req.sample      = s;
        req.last_sample = last;
        pending_samples.push_back(req);
    endtask

    task automatic queue_frame(int unsigned len, fill_mode_t mode);
        for (int unsigned i = 0; i < len; i++)
            add_sample(next_sample(mode), i == len - 1);
    endtask

    task automatic queue_directed();
        add_sample(-16'sd32768, 1'b1);
        add_sample(16'sd0, 1'b1);
        add_sample(16'sd32767, 1'b0);
        add_sample(16'sd0, 1'b0);
        add_sample(16'sd0, 1'b0);
        add_sample(16'sd0, 1'b1);
        add_sample(16'sd0, 1'b0);
        add_sample(16'sd0, 1'b0);
        add_sample(16'sd0, 1'b0);
        add_sample(-16'sd1, 1'b1);
        queue_frame(3, FILL_SILENT);
        add_sample(-16'sd32768, 1'b0);
        add_sample(16'sd32767, 1'b0);
        add_sample(16'sd1, 1'b0);
        add_sample(-16'sd1, 1'b0);
        add_sample(16'sh5555, 1'b0);
        add_sample(-16'sh5556, 1'b0);
        add_sample(16'sd0, 1'b0);
        add_sample(-16'sd32768, 1'b1);
    endtask

    task automatic queue_random(int unsigned items);
        int unsigned pushed;
        int unsigned len;
        fill_mode_t  mode;
        pushed = 0;
        while (pushed < items)
        begin
            len  = ($urandom_range(9) == 0) ? $urandom_range(200, 60)
                                            : $urandom_range(24, 1);
            mode = fill_mode_t'($urandom_range(4));
            queue_frame(len, mode);
            pushed += len;
        end
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || frame_if.valid
               || expected_levels.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        sample_req_t next_req;
        if (!rst_n)
        begin
            frame_if.valid       <= 1'b0;
            frame_if.sample      <= '0;
            frame_if.last_sample <= 1'b0;
            frame_count          = 0;
            frame_energy         = '0;
        end
        else
        begin
            if (frame_if.valid && frame_if.ready)
            begin
                next_req.sample      = frame_if.sample;
                next_req.last_sample = frame_if.last_sample;
                take_sample(next_req);
            end
            if (!frame_if.valid || frame_if.ready)
            begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    next_req              = pending_samples.pop_front();
                    frame_if.valid       <= 1'b1;
                    frame_if.sample      <= next_req.sample;
                    frame_if.last_sample <= next_req.last_sample;
                end
                else
                begin
                    frame_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_proc
        level_rsp_t got;
        level_rsp_t want;
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
        end
        else
        begin
            if (result_if.valid && result_if.ready)
            begin
                got.level         = result_if.level;
                got.prefix_length = result_if.prefix_length;
                got.fraction      = result_if.fraction;
                got.last_level    = result_if.last_level;
                if (expected_levels.size() == 0)
                begin
                    $display("%0t unexpected result: level %0d prefix_length %0d fraction %0d last_level %0b",
                             $time, got.level, got.prefix_length, got.fraction,
                             got.last_level);
                    error_count++;
                end
                else
                begin
                    want = expected_levels.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t mismatch: expected level %0d prefix_length %0d fraction %0d last_level %0b",
                                 $time, want.level, want.prefix_length, want.fraction,
                                 want.last_level);
                        $display("%0t           actual level %0d prefix_length %0d fraction %0d last_level %0b",
                                 $time, got.level, got.prefix_length, got.fraction,
                                 got.last_level);
                        error_count++;
                    end
                end
            end
            result_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int idle_by_phase  [PHASE_COUNT];
        int stall_by_phase [PHASE_COUNT];
        idle_by_phase  = '{0, 64, 0, 31};
        stall_by_phase = '{0, 0, 64, 31};
        rst_n                = 1'b0;
        idle_pct             = 0;
        stall_pct            = 0;
        queue_directed();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        wait_drained();
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            idle_pct  = idle_by_phase[p];
            stall_pct = stall_by_phase[p];
            queue_random(RANDOM_ITEMS / PHASE_COUNT);
            wait_drained();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_levels.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
